FILE: rtl/mcc_pkg.sv
`default_nettype none
package mcc_pkg;

  // Default code widths of the position slot and of the other slots.
  localparam int unsigned PosBitsDef   = 16;
  localparam int unsigned FieldBitsDef = 12;

  // Width of a clamped offset, of a span magnitude and of a quotient.
  localparam int unsigned OpW  = 33;
  localparam int unsigned QuoW = 33;

  // Divider lanes.
  localparam int unsigned NLane  = 5;
  localparam int unsigned LnPos  = 0;
  localparam int unsigned LnVel  = 1;
  localparam int unsigned LnTrq  = 2;
  localparam int unsigned LnKp   = 3;
  localparam int unsigned LnKd   = 4;
  localparam int unsigned NDec   = 3;

  // Command codes.
  localparam logic CmdEncode = 1'b0;
  localparam logic CmdDecode = 1'b1;

  // Register reset values.
  localparam logic signed [31:0] PosMinRst = -32'sd6258688;
  localparam logic signed [31:0] PosMaxRst = 32'sd6258688;
  localparam logic signed [31:0] VelMinRst = -32'sd2949120;
  localparam logic signed [31:0] VelMaxRst = 32'sd2949120;
  localparam logic [30:0]        TrqLimRst = 31'd1179648;
  localparam logic [30:0]        KpLimRst  = 31'd32768000;
  localparam logic [30:0]        KdLimRst  = 31'd327680;

  typedef struct packed {
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic signed [31:0] vel_min;
    logic signed [31:0] vel_max;
    logic [30:0]        torque_limit;
    logic [30:0]        kp_limit;
    logic [30:0]        kd_limit;
    logic               axis_reverse;
  } cfg_t;

  // Sideband that travels with an item through the divider.
  typedef struct packed {
    logic                      cmd;
    logic [7:0]                rid;
    logic                      rev;
    logic [NLane-1:0]          zero;
    logic [NDec-1:0]           neg;
    logic [NDec-1:0][31:0]     lo;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/mcc_prep.sv
`default_nettype none
module mcc_prep #(
  parameter int unsigned PB = mcc_pkg::PosBitsDef,
  parameter int unsigned FB = mcc_pkg::FieldBitsDef,
  parameter int unsigned MBW = (PB > FB) ? PB : FB,
  parameter int unsigned NW = mcc_pkg::OpW + MBW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic                command_i,
  input  wire logic signed [31:0]  pos_des_i,
  input  wire logic signed [31:0]  vel_des_i,
  input  wire logic signed [31:0]  torque_ff_i,
  input  wire logic signed [31:0]  kp_gain_i,
  input  wire logic signed [31:0]  kd_gain_i,
  input  wire logic [47:0]         reply_frame_i,
  input  wire mcc_pkg::cfg_t       cfg_i,
  output logic                     valid_o,
  output mcc_pkg::side_t           side_o,
  output logic [NW-1:0]            num_o [mcc_pkg::NLane],
  output logic [mcc_pkg::OpW-1:0]  den_o [mcc_pkg::NLane]
);
  import mcc_pkg::*;

  localparam logic [MBW-1:0] FullPos = MBW'((1 << PB) - 1);
  localparam logic [MBW-1:0] FullFld = MBW'((1 << FB) - 1);

  // Stage 1: sign the set values, form the spans and capture the reply codes.
  logic               v1_q, cmd1_q, rev1_q;
  logic [7:0]         rid1_q;
  logic signed [32:0] x1_q [NLane];
  logic signed [32:0] lo1_q [NLane];
  logic signed [32:0] hi1_q [NLane];
  logic signed [32:0] span1_q [NLane];
  logic [MBW-1:0]     c1_q [NDec];
  logic signed [32:0] x1_d [NLane];
  logic signed [32:0] lo1_d [NLane];
  logic signed [32:0] hi1_d [NLane];

  always_comb begin
    logic signed [32:0] p, v, t;
    p = {pos_des_i[31], pos_des_i};
    v = {vel_des_i[31], vel_des_i};
    t = {torque_ff_i[31], torque_ff_i};
    x1_d[LnPos] = cfg_i.axis_reverse ? -p : p;
    x1_d[LnVel] = cfg_i.axis_reverse ? -v : v;
    x1_d[LnTrq] = cfg_i.axis_reverse ? -t : t;
    x1_d[LnKp]  = {kp_gain_i[31], kp_gain_i};
    x1_d[LnKd]  = {kd_gain_i[31], kd_gain_i};
    lo1_d[LnPos] = {cfg_i.pos_min[31], cfg_i.pos_min};
    hi1_d[LnPos] = {cfg_i.pos_max[31], cfg_i.pos_max};
    lo1_d[LnVel] = {cfg_i.vel_min[31], cfg_i.vel_min};
    hi1_d[LnVel] = {cfg_i.vel_max[31], cfg_i.vel_max};
    hi1_d[LnTrq] = {2'b00, cfg_i.torque_limit};
    lo1_d[LnTrq] = -{2'b00, cfg_i.torque_limit};
    lo1_d[LnKp]  = '0;
    hi1_d[LnKp]  = {2'b00, cfg_i.kp_limit};
    lo1_d[LnKd]  = '0;
    hi1_d[LnKd]  = {2'b00, cfg_i.kd_limit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= command_i;
    rev1_q <= cfg_i.axis_reverse;
    rid1_q <= reply_frame_i[47:40];
    c1_q[LnPos] <= MBW'(reply_frame_i[24 +: PB]);
    c1_q[LnVel] <= MBW'(reply_frame_i[12 +: FB]);
    c1_q[LnTrq] <= MBW'(reply_frame_i[0 +: FB]);
    for (int l = 0; l < NLane; l++) begin
      x1_q[l]    <= x1_d[l];
      lo1_q[l]   <= lo1_d[l];
      hi1_q[l]   <= hi1_d[l];
      span1_q[l] <= hi1_d[l] - lo1_d[l];
    end
  end

  // Stage 2: clamp, offset from the lower limit and span magnitude.
  logic                 v2_q, cmd2_q, rev2_q;
  logic [7:0]           rid2_q;
  logic [OpW-1:0]       d2_q [NLane];
  logic [OpW-1:0]       abs2_q [NLane];
  logic [NLane-1:0]     zero2_q;
  logic [NDec-1:0]      neg2_q;
  logic [NDec-1:0][31:0] lo2_q;
  logic [MBW-1:0]       c2_q [NDec];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [32:0] y;
    logic signed [33:0] dd;
    cmd2_q <= cmd1_q;
    rev2_q <= rev1_q;
    rid2_q <= rid1_q;
    for (int l = 0; l < NLane; l++) begin
      y = (x1_q[l] < lo1_q[l]) ? lo1_q[l] : x1_q[l];
      y = (y > hi1_q[l]) ? hi1_q[l] : y;
      dd = {y[32], y} - {lo1_q[l][32], lo1_q[l]};
      d2_q[l]    <= dd[OpW-1:0];
      zero2_q[l] <= span1_q[l][32] || (span1_q[l] == '0);
      abs2_q[l]  <= span1_q[l][32] ? OpW'(-span1_q[l]) : OpW'(span1_q[l]);
    end
    for (int l = 0; l < NDec; l++) begin
      neg2_q[l] <= span1_q[l][32];
      lo2_q[l]  <= lo1_q[l][31:0];
      c2_q[l]   <= c1_q[l];
    end
  end

  // Stage 3: numerator and divisor of each lane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [OpW-1:0] a;
    logic [MBW-1:0] b, full;
    for (int l = 0; l < NLane; l++) begin
      full = (l == LnPos) ? FullPos : FullFld;
      if (cmd2_q == CmdEncode) begin
        a = zero2_q[l] ? '0 : d2_q[l];
        b = full;
        den_o[l] <= zero2_q[l] ? OpW'(1) : abs2_q[l];
      end else if (l < NDec) begin
        a = abs2_q[l];
        b = c2_q[l];
        den_o[l] <= OpW'(full);
      end else begin
        a = '0;
        b = '0;
        den_o[l] <= OpW'(1);
      end
      // The product needs the full numerator width.
      num_o[l] <= NW'(a) * NW'(b);
    end
    side_o.cmd  <= cmd2_q;
    side_o.rid  <= rid2_q;
    side_o.rev  <= rev2_q;
    side_o.zero <= zero2_q;
    side_o.neg  <= neg2_q;
    side_o.lo   <= lo2_q;
  end

endmodule
`default_nettype wire

FILE: rtl/mcc_div.sv
`default_nettype none
module mcc_div #(
  parameter int unsigned NW = mcc_pkg::OpW + mcc_pkg::PosBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire mcc_pkg::side_t        side_i,
  input  wire logic [NW-1:0]         num_i [mcc_pkg::NLane],
  input  wire logic [mcc_pkg::OpW-1:0] den_i [mcc_pkg::NLane],
  output logic                       valid_o,
  output mcc_pkg::side_t             side_o,
  output logic [mcc_pkg::QuoW-1:0]   quo_o [mcc_pkg::NLane]
);
  import mcc_pkg::*;

  // One quotient bit per stage, most significant first, all lanes abreast.
  logic [NW-1:0]   rem_q [QuoW][NLane];
  logic [OpW-1:0]  den_q [QuoW][NLane];
  logic [QuoW-1:0] quo_q [QuoW][NLane];
  logic            vld_q [QuoW];
  side_t           side_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - s;
    logic [NW-1:0]   rem_in [NLane];
    logic [OpW-1:0]  den_in [NLane];
    logic [QuoW-1:0] quo_in [NLane];
    logic            vld_in;
    side_t           side_in;

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NLane; l++) begin
          rem_in[l] = num_i[l];
          den_in[l] = den_i[l];
          quo_in[l] = '0;
        end
        vld_in  = valid_i;
        side_in = side_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NLane; l++) begin
          rem_in[l] = rem_q[s-1][l];
          den_in[l] = den_q[s-1][l];
          quo_in[l] = quo_q[s-1][l];
        end
        vld_in  = vld_q[s-1];
        side_in = side_q[s-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      logic ge;
      for (int l = 0; l < NLane; l++) begin
        ge = (rem_in[l] >> Bit) >= NW'(den_in[l]);
        rem_q[s][l] <= ge ? rem_in[l] - (NW'(den_in[l]) << Bit) : rem_in[l];
        quo_q[s][l] <= quo_in[l] | (QuoW'(ge) << Bit);
        den_q[s][l] <= den_in[l];
      end
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];
  always_comb begin
    for (int l = 0; l < NLane; l++) begin
      quo_o[l] = quo_q[QuoW-1][l];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mcc_post.sv
`default_nettype none
module mcc_post #(
  parameter int unsigned PB = mcc_pkg::PosBitsDef,
  parameter int unsigned FB = mcc_pkg::FieldBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire mcc_pkg::side_t        side_i,
  input  wire logic [mcc_pkg::QuoW-1:0] quo_i [mcc_pkg::NLane],
  output logic                       done_o,
  output logic [63:0]                frame_out_o,
  output logic [7:0]                 reply_id_o,
  output logic signed [31:0]         position_o,
  output logic signed [31:0]         velocity_o,
  output logic signed [31:0]         torque_o
);
  import mcc_pkg::*;

  // Stage A: pack the codes, or add the scaled offset to the lower limit.
  logic               va_q, cmda_q, reva_q;
  logic [7:0]         rida_q;
  logic [63:0]        frma_q;
  logic signed [34:0] suma_q [NDec];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [11:0] c [NLane];
    logic [15:0] pc;
    logic signed [33:0] qs;
    pc = side_i.zero[LnPos] ? '0 : 16'(quo_i[LnPos][PB-1:0]);
    for (int l = 1; l < NLane; l++) begin
      c[l] = side_i.zero[l] ? '0 : 12'(quo_i[l][FB-1:0]);
    end
    c[LnPos] = '0;
    frma_q <= {pc, c[LnVel], c[LnKp], c[LnKd], c[LnTrq]};
    for (int l = 0; l < NDec; l++) begin
      qs = side_i.neg[l] ? -$signed({1'b0, quo_i[l]}) : $signed({1'b0, quo_i[l]});
      suma_q[l] <= 35'($signed(side_i.lo[l])) + 35'(qs);
    end
    cmda_q <= side_i.cmd;
    reva_q <= side_i.rev;
    rida_q <= side_i.rid;
  end

  // Stage B: axis sign, saturation and the result register.
  logic signed [31:0] val_b [NDec];

  always_comb begin
    logic signed [35:0] v;
    for (int l = 0; l < NDec; l++) begin
      v = reva_q ? -36'(suma_q[l]) : 36'(suma_q[l]);
      if (v > 36'sd2147483647) begin
        val_b[l] = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
        val_b[l] = 32'sh80000000;
      end else begin
        val_b[l] = v[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmda_q == CmdEncode) begin
      frame_out_o <= frma_q;
      reply_id_o  <= '0;
      position_o  <= '0;
      velocity_o  <= '0;
      torque_o    <= '0;
    end else begin
      frame_out_o <= '0;
      reply_id_o  <= rida_q;
      position_o  <= val_b[LnPos];
      velocity_o  <= val_b[LnVel];
      torque_o    <= val_b[LnTrq];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/motor_can_command_codec.sv
`default_nettype none
// Servo CAN frame codec. A beat is taken on every clock edge at which start
// is high; busy is always low, so a new command may follow in every cycle.
// Each command yields exactly one result beat, marked by done_o for one cycle,
// after preparation (sign, clamp, scaling product), a long divider that
// resolves one quotient bit per stage, and packing and saturation. The
// receiver cannot hold results off, so it must take every result in the
// cycle in which done_o is high. Limits and the axis direction are set over
// the APB port and must only be changed while no command is in flight.
module motor_can_command_codec #(
  parameter int unsigned POS_CODE_BITS   = mcc_pkg::PosBitsDef,
  parameter int unsigned FIELD_CODE_BITS = mcc_pkg::FieldBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Command channel.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic signed [31:0] pos_des_i,
  input  wire logic signed [31:0] vel_des_i,
  input  wire logic signed [31:0] torque_ff_i,
  input  wire logic signed [31:0] kp_gain_i,
  input  wire logic signed [31:0] kd_gain_i,
  input  wire logic [47:0]        reply_frame_i,
  // Result channel.
  output logic                    done_o,
  output logic [63:0]             frame_out_o,
  output logic [7:0]              reply_id_o,
  output logic signed [31:0]      position_o,
  output logic signed [31:0]      velocity_o,
  output logic signed [31:0]      torque_o,
  // Register port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import mcc_pkg::*;

  localparam int unsigned MBW = (POS_CODE_BITS > FIELD_CODE_BITS) ?
                                POS_CODE_BITS : FIELD_CODE_BITS;
  localparam int unsigned NW  = OpW + MBW;

  localparam logic [2:0] RegPosMin = 3'd0;
  localparam logic [2:0] RegPosMax = 3'd1;
  localparam logic [2:0] RegVelMin = 3'd2;
  localparam logic [2:0] RegVelMax = 3'd3;
  localparam logic [2:0] RegTrqLim = 3'd4;
  localparam logic [2:0] RegKpLim  = 3'd5;
  localparam logic [2:0] RegKdLim  = 3'd6;
  localparam logic [2:0] RegAxis   = 3'd7;

  // The pipeline never stalls, so the command side is always ready.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers.
  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min      <= PosMinRst;
      cfg_q.pos_max      <= PosMaxRst;
      cfg_q.vel_min      <= VelMinRst;
      cfg_q.vel_max      <= VelMaxRst;
      cfg_q.torque_limit <= TrqLimRst;
      cfg_q.kp_limit     <= KpLimRst;
      cfg_q.kd_limit     <= KdLimRst;
      cfg_q.axis_reverse <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegPosMin: cfg_q.pos_min      <= pwdata;
        RegPosMax: cfg_q.pos_max      <= pwdata;
        RegVelMin: cfg_q.vel_min      <= pwdata;
        RegVelMax: cfg_q.vel_max      <= pwdata;
        RegTrqLim: cfg_q.torque_limit <= pwdata[30:0];
        RegKpLim:  cfg_q.kp_limit     <= pwdata[30:0];
        RegKdLim:  cfg_q.kd_limit     <= pwdata[30:0];
        RegAxis:   cfg_q.axis_reverse <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPosMin: prdata = cfg_q.pos_min;
      RegPosMax: prdata = cfg_q.pos_max;
      RegVelMin: prdata = cfg_q.vel_min;
      RegVelMax: prdata = cfg_q.vel_max;
      RegTrqLim: prdata = {1'b0, cfg_q.torque_limit};
      RegKpLim:  prdata = {1'b0, cfg_q.kp_limit};
      RegKdLim:  prdata = {1'b0, cfg_q.kd_limit};
      RegAxis:   prdata = {31'd0, cfg_q.axis_reverse};
      default:   prdata = '0;
    endcase
  end

  // Preparation: sign, clamp and form each lane's numerator and divisor.
  logic          prep_vld;
  side_t         prep_side;
  logic [NW-1:0] prep_num [NLane];
  logic [OpW-1:0] prep_den [NLane];

  mcc_prep #(
    .PB  (POS_CODE_BITS),
    .FB  (FIELD_CODE_BITS),
    .MBW (MBW),
    .NW  (NW)
  ) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .command_i     (command_i),
    .pos_des_i     (pos_des_i),
    .vel_des_i     (vel_des_i),
    .torque_ff_i   (torque_ff_i),
    .kp_gain_i     (kp_gain_i),
    .kd_gain_i     (kd_gain_i),
    .reply_frame_i (reply_frame_i),
    .cfg_i         (cfg_q),
    .valid_o       (prep_vld),
    .side_o        (prep_side),
    .num_o         (prep_num),
    .den_o         (prep_den)
  );

  // Long division, all five lanes side by side.
  logic            div_vld;
  side_t           div_side;
  logic [QuoW-1:0] div_quo [NLane];

  mcc_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .side_i  (prep_side),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (div_quo)
  );

  // Packing of the command frame, or offset, sign and saturation of a reply.
  mcc_post #(
    .PB (POS_CODE_BITS),
    .FB (FIELD_CODE_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (div_vld),
    .side_i      (div_side),
    .quo_i       (div_quo),
    .done_o      (done_o),
    .frame_out_o (frame_out_o),
    .reply_id_o  (reply_id_o),
    .position_o  (position_o),
    .velocity_o  (velocity_o),
    .torque_o    (torque_o)
  );

endmodule
`default_nettype wire
